// ----- rtl/sqlt_pkg.sv -----
package sqlt_pkg;

  // token kinds
  localparam logic [4:0] KIND_END      = 5'd0;
  localparam logic [4:0] KIND_IDENT    = 5'd1;
  localparam logic [4:0] KIND_KW_BASE  = 5'd2;   // SELECT, FROM, WHERE, DISTINCT, AS
  localparam logic [4:0] KIND_NUMBER   = 5'd7;
  localparam logic [4:0] KIND_DOT      = 5'd8;
  localparam logic [4:0] KIND_COMMA    = 5'd9;
  localparam logic [4:0] KIND_SEMI     = 5'd10;
  localparam logic [4:0] KIND_PLUS     = 5'd11;
  localparam logic [4:0] KIND_MINUS    = 5'd12;
  localparam logic [4:0] KIND_STAR     = 5'd13;
  localparam logic [4:0] KIND_LT       = 5'd14;
  localparam logic [4:0] KIND_GT       = 5'd15;
  localparam logic [4:0] KIND_EQ       = 5'd16;
  localparam logic [4:0] KIND_LPAREN   = 5'd17;
  localparam logic [4:0] KIND_RPAREN   = 5'd18;
  localparam logic [4:0] KIND_QUOTE    = 5'd19;
  localparam logic [4:0] KIND_ERROR    = 5'd20;

  localparam int          NUM_KW   = 5;
  localparam logic [30:0] ACC_MAX  = 31'h7FFF_FFFF;
  localparam logic [15:0] LINE_MAX = 16'hFFFF;
  localparam logic [11:0] COL_MAX  = 12'hFFF;

  // keyword text, upper case, first char in the top byte, space padded
  localparam logic [63:0] KW_TEXT [NUM_KW] = '{
    "SELECT  ", "FROM    ", "WHERE   ", "DISTINCT", "AS      "
  };
  localparam logic [3:0] KW_LEN [NUM_KW] = '{4'd6, 4'd4, 4'd5, 4'd8, 4'd2};

  // one result item
  typedef struct packed {
    logic [4:0]  kind;
    logic [30:0] number_value;
    logic        overflow;
    logic [15:0] token_line;
    logic [11:0] token_column;
    logic [7:0]  token_length;
    logic        last;
  } result_t;

  // results produced by one input item, in order
  typedef struct packed {
    logic [1:0] n_items;
    result_t    first;
    result_t    second;
  } push_t;

  // drop keyword candidates that do not match character c at position pos;
  // bits 0-4 upper-case spellings, bits 5-9 lower-case
  function automatic logic [9:0] kw_filter(logic [9:0] cand, logic [7:0] c,
                                           logic pos_ok, logic [2:0] pos);
    logic [9:0] res;
    logic [7:0] up;
    logic       in_len;
    res = cand;
    for (int k = 0; k < NUM_KW; k++) begin
      up     = KW_TEXT[k][63 - 8 * pos -: 8];
      in_len = pos_ok && ({1'b0, pos} < KW_LEN[k]);
      if (!(in_len && c == up)) res[k] = 1'b0;
      if (!(in_len && c == (up | 8'h20))) res[k + NUM_KW] = 1'b0;
    end
    return res;
  endfunction

  // single-character token kind, error for anything unknown
  function automatic logic [4:0] punct_kind(logic [7:0] c);
    logic [4:0] k;
    case (c)
      8'h2E:   k = KIND_DOT;      // .
      8'h2C:   k = KIND_COMMA;    // ,
      8'h3B:   k = KIND_SEMI;     // ;
      8'h2B:   k = KIND_PLUS;     // +
      8'h2D:   k = KIND_MINUS;    // -
      8'h2A:   k = KIND_STAR;     // *
      8'h3C:   k = KIND_LT;       // <
      8'h3E:   k = KIND_GT;       // >
      8'h3D:   k = KIND_EQ;       // =
      8'h28:   k = KIND_LPAREN;   // (
      8'h29:   k = KIND_RPAREN;   // )
      8'h22:   k = KIND_QUOTE;    // "
      default: k = KIND_ERROR;
    endcase
    return k;
  endfunction

endpackage

// ----- rtl/sqlt_scan.sv -----
module sqlt_scan #(
  parameter int MAX_TOKEN_LENGTH = 255
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           fire,
  input  logic [7:0]     ch,
  input  logic           end_of_text,
  output sqlt_pkg::push_t push
);

  localparam int RUN_W = $clog2(MAX_TOKEN_LENGTH + 1);

  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_NUMBER = 2'd1;
  localparam logic [1:0] MODE_WORD   = 2'd2;
  localparam logic [1:0] MODE_HALTED = 2'd3;

  logic [1:0]       mode, mode_next;
  logic [30:0]      acc, acc_next;
  logic             acc_ovf, acc_ovf_next;
  logic [9:0]       cand, cand_next;
  logic [15:0]      start_line, start_line_next;
  logic [11:0]      start_col, start_col_next;
  logic [15:0]      cur_line, cur_line_next;
  logic [11:0]      cur_col, cur_col_next;
  logic [RUN_W-1:0] run, run_next;

  // character classes
  logic is_digit, is_letter, is_sep, is_us;
  assign is_digit  = (ch >= 8'h30) && (ch <= 8'h39);
  assign is_letter = ((ch >= 8'h41) && (ch <= 8'h5A)) || ((ch >= 8'h61) && (ch <= 8'h7A));
  assign is_sep    = (ch == 8'h20) || (ch == 8'h09) || (ch == 8'h0A);
  assign is_us     = (ch == 8'h5F);

  // position after this character
  logic [15:0] line_adv;
  logic [11:0] col_adv;
  always_comb begin
    line_adv = cur_line;
    col_adv  = cur_col;
    if (ch == 8'h0A) begin
      if (cur_line != sqlt_pkg::LINE_MAX) line_adv = cur_line + 16'd1;
      col_adv = 12'd1;
    end else if (cur_col != sqlt_pkg::COL_MAX) begin
      col_adv = cur_col + 12'd1;
    end
  end

  // acc * 10 + digit with saturation
  logic [34:0] acc_mul;
  logic [30:0] acc_sat;
  logic        acc_sat_ovf;
  assign acc_mul = 35'({acc, 3'b000}) + 35'({acc, 1'b0}) + 35'(ch[3:0]);
  assign acc_sat_ovf = (acc_mul > 35'(sqlt_pkg::ACC_MAX));
  assign acc_sat = acc_sat_ovf ? sqlt_pkg::ACC_MAX : acc_mul[30:0];

  // run length helpers
  logic             run_pos_ok;
  logic [RUN_W-1:0] run_bump;
  logic [7:0]       len_sat;
  assign run_pos_ok = (32'(run) < 32'd8);
  assign run_bump   = (32'(run) < MAX_TOKEN_LENGTH) ? run + 1'b1 : run;
  assign len_sat    = (32'(run) > 32'd255) ? 8'hFF : 8'(run);

  // kind of the word now pending
  logic [4:0] word_kind;
  always_comb begin
    word_kind = sqlt_pkg::KIND_IDENT;
    for (int k = 0; k < sqlt_pkg::NUM_KW; k++) begin
      if ((cand[k] || cand[k + sqlt_pkg::NUM_KW]) &&
          (32'(run) == 32'(sqlt_pkg::KW_LEN[k])))
        word_kind = sqlt_pkg::KIND_KW_BASE + 5'(k);
    end
  end

  // one item of work
  sqlt_pkg::result_t pend, own;
  logic flush, own_valid;
  always_comb begin
    mode_next       = mode;
    acc_next        = acc;
    acc_ovf_next    = acc_ovf;
    cand_next       = cand;
    start_line_next = start_line;
    start_col_next  = start_col;
    cur_line_next   = cur_line;
    cur_col_next    = cur_col;
    run_next        = run;
    flush           = 1'b0;
    own_valid       = 1'b0;

    pend.kind         = (mode == MODE_NUMBER) ? sqlt_pkg::KIND_NUMBER : word_kind;
    pend.number_value = (mode == MODE_NUMBER) ? acc : '0;
    pend.overflow     = (mode == MODE_NUMBER) ? acc_ovf : 1'b0;
    pend.token_line   = start_line;
    pend.token_column = start_col;
    pend.token_length = len_sat;
    pend.last         = 1'b0;

    own.kind         = sqlt_pkg::punct_kind(ch);
    own.number_value = '0;
    own.overflow     = 1'b0;
    own.token_line   = cur_line;
    own.token_column = cur_col;
    own.token_length = 8'd1;
    own.last         = 1'b0;

    if (fire && mode != MODE_HALTED) begin
      if (end_of_text) begin
        flush            = (mode != MODE_IDLE);
        own_valid        = 1'b1;
        own.kind         = sqlt_pkg::KIND_END;
        own.token_length = 8'd0;
        mode_next        = MODE_IDLE;
      end else if (mode == MODE_NUMBER && is_digit) begin
        acc_next      = acc_sat;
        acc_ovf_next  = acc_ovf | acc_sat_ovf;
        run_next      = run_bump;
        cur_line_next = line_adv;
        cur_col_next  = col_adv;
      end else if (mode == MODE_WORD && (is_letter || is_digit || is_us)) begin
        cand_next     = sqlt_pkg::kw_filter(cand, ch, run_pos_ok, run[2:0]);
        run_next      = run_bump;
        cur_line_next = line_adv;
        cur_col_next  = col_adv;
      end else begin
        flush     = (mode != MODE_IDLE);
        mode_next = MODE_IDLE;
        if (is_sep) begin
          // separator: nothing to start
        end else if (is_digit) begin
          mode_next       = MODE_NUMBER;
          start_line_next = cur_line;
          start_col_next  = cur_col;
          acc_next        = 31'(ch[3:0]);
          acc_ovf_next    = 1'b0;
          run_next        = RUN_W'(1);
        end else if (is_letter) begin
          mode_next       = MODE_WORD;
          start_line_next = cur_line;
          start_col_next  = cur_col;
          cand_next       = sqlt_pkg::kw_filter('1, ch, 1'b1, 3'd0);
          run_next        = RUN_W'(1);
        end else begin
          own_valid = 1'b1;
          if (own.kind == sqlt_pkg::KIND_ERROR) mode_next = MODE_HALTED;
        end
        cur_line_next = line_adv;
        cur_col_next  = col_adv;
      end
    end

    // order the results, pending token first
    push = '0;
    if (flush && own_valid) begin
      push.n_items     = 2'd2;
      push.first       = pend;
      push.second      = own;
      push.second.last = 1'b1;
    end else if (flush) begin
      push.n_items    = 2'd1;
      push.first      = pend;
      push.first.last = 1'b1;
    end else if (own_valid) begin
      push.n_items    = 2'd1;
      push.first      = own;
      push.first.last = 1'b1;
    end
  end

  // scanner state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      acc        <= '0;
      acc_ovf    <= 1'b0;
      cand       <= '1;
      start_line <= 16'd1;
      start_col  <= 12'd1;
      cur_line   <= 16'd1;
      cur_col    <= 12'd1;
      run        <= '0;
    end else begin
      mode       <= mode_next;
      acc        <= acc_next;
      acc_ovf    <= acc_ovf_next;
      cand       <= cand_next;
      start_line <= start_line_next;
      start_col  <= start_col_next;
      cur_line   <= cur_line_next;
      cur_col    <= cur_col_next;
      run        <= run_next;
    end
  end

  // two results only when a number or word is closed by a token
  a_two_results: assert property (@(posedge clk) disable iff (rst)
    push.n_items == 2'd2 |-> (push.first.kind >= sqlt_pkg::KIND_IDENT) &&
      (push.first.kind <= sqlt_pkg::KIND_NUMBER) && !push.first.last && push.second.last)
    else $error("two results without a pending token first");

  a_halted_silent: assert property (@(posedge clk) disable iff (rst)
    mode == MODE_HALTED |-> push.n_items == 2'd0)
    else $error("result produced while halted");

  a_error_halts: assert property (@(posedge clk) disable iff (rst)
    (push.n_items != 2'd0) && push.first.last &&
      (push.first.kind == sqlt_pkg::KIND_ERROR) |=> mode == MODE_HALTED)
    else $error("error token did not halt the scanner");

  a_no_three: assert property (@(posedge clk) disable iff (rst)
    push.n_items != 2'd3)
    else $error("more than two results for one item");

endmodule

// ----- rtl/sqlt_outq.sv -----
module sqlt_outq (
  input  logic                clk,
  input  logic                rst,
  input  sqlt_pkg::push_t     push,
  input  logic                pop,
  output logic                has_room,
  output logic                not_empty,
  output sqlt_pkg::result_t   head
);

  sqlt_pkg::result_t q [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count;

  assign not_empty = (count != 3'd0);
  assign has_room  = (count <= 3'd2);
  assign head      = q[rd_ptr];

  // result storage
  always_ff @(posedge clk) begin
    if (push.n_items != 2'd0) q[wr_ptr] <= push.first;
    if (push.n_items == 2'd2) q[wr_ptr + 2'd1] <= push.second;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push.n_items;
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count + 3'(push.n_items) - 3'(pop);
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    push.n_items != 2'd0 |-> count <= 3'd2)
    else $error("result queue written without room");

  a_level: assert property (@(posedge clk) disable iff (rst)
    count <= 3'd4)
    else $error("result queue level out of range");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != 3'd0)
    else $error("result queue read while empty");

endmodule

// ----- rtl/sql_subset_tokenizer.sv -----
// Channel   Dir  Signals                               Contents
// s_axis    in   tvalid tready tdata[7:0] tuser[0]     character, end-of-text mark
// m_axis    out  tvalid tready tdata[71:0] tuser[4:0]  token fields, kind, tlast
//
// One item is accepted per cycle while the queue has room; it is scanned from its input
// register, and its results are written to a four-entry result queue. Results pass
// through the input register and the result queue before they leave. Results leave
// one per cycle while m_axis is ready, so an item that gives two results gives two output transfers; the
// queue level (room for two results) sets ready. Reset is synchronous and
// clears the scanner to idle at line 1, column 1 and empties the queue.
// A stall on m_axis fills the queue and then holds off s_axis.
module sql_subset_tokenizer #(
  parameter int MAX_TOKEN_LENGTH = 255
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // ch[7:0]
  input  logic [0:0]  s_axis_tuser,   // end_of_text[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // number_value[30:0], overflow[31], token_line[47:32],
                                      // token_column[59:48], token_length[67:60], zero[71:68]
  output logic [4:0]  m_axis_tuser,   // kind[4:0]
  output logic        m_axis_tlast
);

  logic              in_valid;
  logic [7:0]        in_ch;
  logic              in_eot;
  logic              fire;
  logic              has_room;
  sqlt_pkg::push_t   push;
  sqlt_pkg::result_t head;

  assign fire          = in_valid && has_room;
  assign s_axis_tready = !in_valid || fire;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_ch  <= s_axis_tdata;
      in_eot <= s_axis_tuser[0];
    end
  end

  sqlt_scan #(
    .MAX_TOKEN_LENGTH(MAX_TOKEN_LENGTH)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .ch          (in_ch),
    .end_of_text (in_eot),
    .push        (push)
  );

  sqlt_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (m_axis_tvalid && m_axis_tready),
    .has_room  (has_room),
    .not_empty (m_axis_tvalid),
    .head      (head)
  );

  // output packing
  assign m_axis_tdata = {4'b0000, head.token_length, head.token_column, head.token_line,
                         head.overflow, head.number_value};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

endmodule
